// File: rtl/core/cpca_pkg.sv
package cpca_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 8;
  localparam int ShoeBits  = 2 * CoordBits + 16;
  localparam int AreaBits  = 2 * CoordBits + 2;
  localparam int PerimBits = CoordBits + 2 + FracBits;
  localparam int DiffBits  = CoordBits + 1;
  localparam int RadBits   = 2 * DiffBits + 2;
  localparam int RootSteps = RadBits / 2 + FracBits;
  localparam int RootBits  = RootSteps;
  localparam int RemBits   = RootBits + 2;
  localparam int CntBits   = $clog2(RootSteps + 2);
  localparam int CrossBits = 2 * DiffBits + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
    logic                        final_vertex;
  } in_beat_t;

  typedef struct packed {
    logic                 is_convex;
    logic                 too_few_vertices;
    logic [AreaBits-1:0]  doubled_area;
    logic [PerimBits-1:0] perimeter_q8;
  } out_beat_t;

  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_POS  = 2'd1,
    TURN_NEG  = 2'd2
  } turn_e;

  typedef enum logic [1:0] {
    OP_EDGE   = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_FEW    = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // One edge job for the back end; on a close the front has already folded turns.
  typedef struct packed {
    op_e                         op;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic                        convex;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_ROOT = 2'd2,
    BK_OUT  = 2'd3
  } back_state_e;

  typedef enum logic [1:0] {
    FR_TAKE  = 2'd0,
    FR_TURN1 = 2'd1,
    FR_TURN2 = 2'd2,
    FR_PUSH  = 2'd3
  } front_state_e;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } front_phase_e;

endpackage

// File: rtl/core/cpca_queue.sv
module cpca_queue
  import cpca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t pop_data_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

endmodule

// File: rtl/core/cpca_front.sv
module cpca_front
  import cpca_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_beat_t in_data_i,
  output logic     push_o,
  output job_t     push_data_o,
  input  logic     full_i
);

  front_state_e state_q, state_d;
  logic signed [CoordBits-1:0] fx_q, fy_q, sx_q, sy_q, ox_q, oy_q, nx_q, ny_q;
  logic signed [CoordBits-1:0] cx_q, cy_q;
  logic        last_q;
  logic [1:0]  seen_q;
  turn_e       ref_q;
  logic        conv_q;
  logic        edge_q;

  // Shared turn unit: two products registered, compared next cycle.
  logic signed [CoordBits-1:0] tax, tay, tbx, tby, tcx, tcy;
  logic signed [CrossBits-1:0] p1_q, p2_q;
  logic        tv_q;
  logic signed [CrossBits:0]   tv;
  turn_e       t;
  logic        take_turn;

  always_comb begin
    tax = ox_q; tay = oy_q; tbx = nx_q; tby = ny_q; tcx = cx_q; tcy = cy_q;
    if (state_q == FR_TURN1) begin
      tax = ox_q; tay = oy_q; tbx = nx_q; tby = ny_q; tcx = fx_q; tcy = fy_q;
    end else if (state_q == FR_TURN2) begin
      tax = nx_q; tay = ny_q; tbx = fx_q; tby = fy_q; tcx = sx_q; tcy = sy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= CrossBits'((DiffBits'(tby) - DiffBits'(tay)) * (DiffBits'(tcx) - DiffBits'(tbx)));
    p2_q <= CrossBits'((DiffBits'(tbx) - DiffBits'(tax)) * (DiffBits'(tcy) - DiffBits'(tby)));
  end

  assign tv = (CrossBits+1)'(p1_q) - (CrossBits+1)'(p2_q);
  assign t  = tv == '0 ? TURN_NONE : (tv[CrossBits] ? TURN_NEG : TURN_POS);

  front_phase_e ph_q, ph_d;

  assign in_stall_o = !(state_q == FR_TAKE && ph_q == PH_A && !full_i);
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    push_o      = 1'b0;
    take_turn   = 1'b0;
    push_data_o = '{op: OP_EDGE, ax: nx_q, ay: ny_q, bx: cx_q, by: cy_q, convex: conv_q};
    case (state_q)
      FR_TAKE: begin
        if (ph_q == PH_B) begin
          ph_d = PH_C;
        end else if (ph_q == PH_C) begin
          take_turn = tv_q;
          push_o    = edge_q;
          ph_d      = PH_A;
          if (last_q) state_d = (seen_q >= 2'd2) ? FR_TURN1 : FR_PUSH;
        end
      end
      FR_TURN1: begin
        if (ph_q == PH_A) ph_d = PH_B;
        else begin
          take_turn = 1'b1; ph_d = PH_A; state_d = FR_TURN2;
        end
      end
      FR_TURN2: begin
        if (ph_q == PH_A) ph_d = PH_B;
        else begin
          take_turn = 1'b1; ph_d = PH_A; state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        push_data_o = '{op: (seen_q == 2'd3) ? OP_CLOSE : OP_FEW, ax: nx_q, ay: ny_q,
                        bx: fx_q, by: fy_q, convex: conv_q};
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FR_TAKE;
        end
      end
      default: state_d = FR_TAKE;
    endcase
    if (acc) ph_d = PH_B;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_TAKE;
      ph_q    <= PH_A;
      fx_q <= '0; fy_q <= '0; sx_q <= '0; sy_q <= '0;
      ox_q <= '0; oy_q <= '0; nx_q <= '0; ny_q <= '0;
      cx_q <= '0; cy_q <= '0;
      last_q <= 1'b0; seen_q <= 2'd0; ref_q <= TURN_NONE; conv_q <= 1'b1;
      tv_q <= 1'b0; edge_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      if (take_turn) begin
        if (t == TURN_NONE || (ref_q != TURN_NONE && t != ref_q)) conv_q <= 1'b0;
        if (ref_q == TURN_NONE) ref_q <= t;
      end
      if (state_q == FR_TAKE && ph_q == PH_C) begin
        ox_q <= nx_q; oy_q <= ny_q; nx_q <= cx_q; ny_q <= cy_q;
        if (seen_q == 2'd0) begin fx_q <= cx_q; fy_q <= cy_q; end
        if (seen_q == 2'd1) begin sx_q <= cx_q; sy_q <= cy_q; end
        if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
      end
      if (acc) begin
        cx_q   <= in_data_i.vertex_x;
        cy_q   <= in_data_i.vertex_y;
        last_q <= in_data_i.final_vertex;
        tv_q   <= seen_q >= 2'd2;
        edge_q <= seen_q != 2'd0;
      end
      if (state_q == FR_PUSH && !full_i) begin
        fx_q <= '0; fy_q <= '0; sx_q <= '0; sy_q <= '0;
        ox_q <= '0; oy_q <= '0; nx_q <= '0; ny_q <= '0;
        seen_q <= 2'd0; ref_q <= TURN_NONE; conv_q <= 1'b1; last_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/cpca_back.sv
module cpca_back
  import cpca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  back_state_e state_q, state_d;
  job_t        job_q;
  logic signed [CoordBits-1:0] ax, ay, bx, by;
  logic signed [CrossBits-1:0] m1_q, m2_q;
  logic [RadBits-1:0]  rad_q;
  logic [RemBits-1:0]  rem_q;
  logic [RootBits-1:0] root_q;
  logic [CntBits-1:0]  cnt_q;
  logic [ShoeBits-1:0] shoe_q;
  logic [PerimBits-1:0] len_q;
  logic [DiffBits-1:0] adx, ady;
  logic signed [DiffBits-1:0] dx, dy;
  logic [2*DiffBits-1:0] sqx_q, sqy_q;
  logic [RemBits-1:0]  rem_sh, trial;
  logic [1:0]          pair;
  logic [PerimBits:0]  lsum;
  logic [ShoeBits-1:0] shoe_abs;
  logic                outv_q;
  out_beat_t           out_q;

  assign ax = job_q.ax; assign ay = job_q.ay; assign bx = job_q.bx; assign by = job_q.by;
  assign dx = DiffBits'(bx) - DiffBits'(ax);
  assign dy = DiffBits'(by) - DiffBits'(ay);
  assign adx = dx[DiffBits-1] ? DiffBits'(-dx) : DiffBits'(dx);
  assign ady = dy[DiffBits-1] ? DiffBits'(-dy) : DiffBits'(dy);

  assign pair   = (cnt_q <= CntBits'(RadBits / 2)) ?
                  rad_q[RadBits-1 -: 2] : 2'b00;
  assign rem_sh = {rem_q[RemBits-3:0], pair};
  assign trial  = {root_q[RemBits-3:0], 2'b01};
  assign lsum   = {1'b0, len_q} + (PerimBits+1)'(root_q);
  assign shoe_abs = shoe_q[ShoeBits-1] ? -shoe_q : shoe_q;

  assign pop_o       = state_q == BK_IDLE && !empty_i && !(outv_q && out_stall_i);
  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (pop_o) state_d = (job_i.op == OP_FEW) ? BK_OUT : BK_MUL;
      BK_MUL:  state_d = BK_ROOT;
      BK_ROOT: if (cnt_q == CntBits'(RootSteps + 1)) state_d =
                 (job_q.op == OP_CLOSE) ? BK_OUT : BK_IDLE;
      BK_OUT:  if (!(outv_q && out_stall_i)) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (state_q == BK_MUL) begin
      m1_q  <= CrossBits'(ax * by);
      m2_q  <= CrossBits'(ay * bx);
      sqx_q <= adx * adx;
      sqy_q <= ady * ady;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      outv_q  <= 1'b0;
      out_q   <= '0;
      shoe_q  <= '0;
      len_q   <= '0;
      rad_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (outv_q && !out_stall_i) outv_q <= 1'b0;
      if (state_q == BK_MUL) begin
        cnt_q  <= '0;
        rem_q  <= '0;
        root_q <= '0;
        rad_q  <= '0;
      end
      if (state_q == BK_ROOT) begin
        if (cnt_q == '0) begin
          rad_q  <= RadBits'(sqx_q) + RadBits'(sqy_q);
          shoe_q <= shoe_q + ShoeBits'(m1_q) - ShoeBits'(m2_q);
          cnt_q  <= cnt_q + 1'b1;
        end else if (cnt_q != CntBits'(RootSteps + 1)) begin
          rad_q <= {rad_q[RadBits-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[RootBits-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[RootBits-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
        end else begin
          len_q <= lsum[PerimBits] ? '1 : lsum[PerimBits-1:0];
        end
      end
      if (state_q == BK_OUT && !(outv_q && out_stall_i)) begin
        outv_q <= 1'b1;
        if (job_q.op == OP_FEW) begin
          out_q <= '{is_convex: 1'b0, too_few_vertices: 1'b1,
                     doubled_area: '0, perimeter_q8: '0};
        end else if (job_q.convex) begin
          out_q <= '{is_convex: 1'b1, too_few_vertices: 1'b0,
                     doubled_area: (|shoe_abs[ShoeBits-1:AreaBits]) ? '1 :
                                   shoe_abs[AreaBits-1:0],
                     perimeter_q8: len_q};
        end else begin
          out_q <= '0;
        end
        shoe_q <= '0;
        len_q  <= '0;
      end
    end
  end

endmodule

// File: rtl/core/convex_polygon_check_area_perimeter.sv
// Channel   Direction  Handshake           Beat
// in        input      in_valid/in_stall   vertex x, y, final flag
// out       output     out_valid/out_stall convexity, area, perimeter
// Front end per vertex: accept, cross products, then fold turns and push the edge;
// back end per edge: pop, products, then a bit-serial root for the length.
// A final vertex adds front-end steps for the wrap-around turns and the close or too-few job;
// the result is registered in BK_OUT after the closing edge and holds while out_stall is high.
// A two-entry queue decouples front and back; input stalls while it is full.
// Reset is asynchronous, active low.
module convex_polygon_check_area_perimeter
  import cpca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic push, full, pop, empty;
  job_t push_data, pop_data;

  cpca_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  cpca_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  cpca_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(pop_data), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
